FILE: rtl/bmcc_pkg.sv
// bmcc_pkg: shared types and constants for the button multi-click classifier
// no dependencies; used by button_multi_click_classifier_core
package bmcc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_CFG_W = 16;
  localparam int unsigned BIT_SEL_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W = 48;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [BIT_SEL_W-1:0] BUTTON_BIT_RST   = 3'd0;
  localparam logic [MS_CFG_W-1:0]  LONG_PRESS_RST   = 16'd1000;
  localparam logic [MS_CFG_W-1:0]  MULTI_WINDOW_RST = 16'd280;
  localparam logic [MS_CFG_W-1:0]  REPEAT_DELAY_RST = 16'd700;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_BIT   = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_MULTI_WINDOW = 2'd2,
    REG_REPEAT_DELAY = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_POLL   = 1'b0,
    CMD_CANCEL = 1'b1
  } cmd_t;

endpackage

FILE: rtl/button_multi_click_classifier_core.sv
// button_multi_click_classifier_core: classifies polled button samples into
// click, double, triple and long-press events; depends on bmcc_pkg
//
// One result beat is produced for every input beat. The block takes a new beat
// every clock cycle while results are taken: a beat is captured in an input
// register, classified against the press/click state by combinational
// compare-and-update logic, and written to the result register once that is
// free, which raises out_tvalid. While a result waits to be taken, one more beat
// is held in the input register and in_tready then drops until out_tready
// returns. All time differences wrap modulo 2^32. Registers are written through
// cfg_we/cfg_index/cfg_wdata; the user must do so only while idle (not enforced).
module button_multi_click_classifier_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // port_byte[7:0], read_ok[8], now_ms[40:9], repeat_on[41], zero[47:42]
  input  logic [bmcc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // event_res[2:0], pressed_now[3], zero[7:4]
  output logic [bmcc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [bmcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmcc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned TW = bmcc_pkg::TIME_W;
  localparam int unsigned MW = bmcc_pkg::MS_CFG_W;

  // configuration
  logic [bmcc_pkg::BIT_SEL_W-1:0] button_bit_r;
  logic [MW-1:0] long_press_r;
  logic [MW-1:0] window_r;
  logic [MW-1:0] repeat_delay_r;

  // input register
  logic          s1_valid_r;
  logic          s1_cmd_r;
  logic [7:0]    s1_port_r;
  logic          s1_ok_r;
  logic [TW-1:0] s1_now_r;
  logic          s1_rep_r;

  // classifier state
  logic          prev_level_r, prev_level_nxt;
  logic          held_r, held_nxt;
  logic [TW-1:0] press_time_r, press_time_nxt;
  logic [1:0]    click_count_r, click_count_nxt;
  logic [TW-1:0] last_click_r, last_click_nxt;
  logic          pending_r, pending_nxt;

  // result register
  logic                 out_valid_r;
  bmcc_pkg::event_t     out_event_r, event_nxt;
  logic                 out_pressed_r, pressed_nxt;

  logic out_free;
  logic advance;
  logic btn;
  logic [TW-1:0] press_age;
  logic [TW-1:0] click_age;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_pressed_r, out_event_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_bit_r   <= bmcc_pkg::BUTTON_BIT_RST;
      long_press_r   <= bmcc_pkg::LONG_PRESS_RST;
      window_r       <= bmcc_pkg::MULTI_WINDOW_RST;
      repeat_delay_r <= bmcc_pkg::REPEAT_DELAY_RST;
    end else if (cfg_we) begin
      unique case (bmcc_pkg::cfg_reg_t'(cfg_index))
        bmcc_pkg::REG_BUTTON_BIT:   button_bit_r   <= cfg_wdata[bmcc_pkg::BIT_SEL_W-1:0];
        bmcc_pkg::REG_LONG_PRESS:   long_press_r   <= cfg_wdata[MW-1:0];
        bmcc_pkg::REG_MULTI_WINDOW: window_r       <= cfg_wdata[MW-1:0];
        bmcc_pkg::REG_REPEAT_DELAY: repeat_delay_r <= cfg_wdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_port_r <= in_tdata[7:0];
      s1_ok_r   <= in_tdata[8];
      s1_now_r  <= in_tdata[40:9];
      s1_rep_r  <= in_tdata[41];
    end
  end

  always_comb begin
    prev_level_nxt  = prev_level_r;
    held_nxt        = held_r;
    press_time_nxt  = press_time_r;
    click_count_nxt = click_count_r;
    last_click_nxt  = last_click_r;
    pending_nxt     = pending_r;
    event_nxt       = bmcc_pkg::EV_NONE;
    btn             = s1_ok_r && !s1_port_r[button_bit_r];
    pressed_nxt     = btn;
    press_age       = s1_now_r - press_time_r;
    click_age       = '0;

    if (bmcc_pkg::cmd_t'(s1_cmd_r) == bmcc_pkg::CMD_CANCEL) begin
      held_nxt        = 1'b0;
      press_time_nxt  = '0;
      click_count_nxt = '0;
      last_click_nxt  = '0;
      pending_nxt     = 1'b0;
      pressed_nxt     = prev_level_r;
    end else begin
      if (btn != prev_level_r) begin
        if (btn) begin
          held_nxt       = 1'b1;
          press_time_nxt = s1_now_r;
          press_age      = '0;
        end else begin
          if ((long_press_r == '0) ||
              (held_r && (press_age < {{(TW-MW){1'b0}}, long_press_r}))) begin
            if (click_count_r != 2'd3) begin
              click_count_nxt = click_count_r + 2'd1;
            end
            last_click_nxt = s1_now_r;
            pending_nxt    = 1'b1;
          end
          held_nxt       = 1'b0;
          press_time_nxt = '0;
        end
        prev_level_nxt = btn;
      end

      if ((long_press_r != '0) && held_nxt &&
          (press_age >= {{(TW-MW){1'b0}}, long_press_r})) begin
        if (!pending_nxt) begin
          event_nxt = bmcc_pkg::EV_LONG;
        end
        held_nxt        = 1'b0;
        press_time_nxt  = '0;
        click_count_nxt = '0;
        last_click_nxt  = '0;
        pending_nxt     = 1'b0;
      end

      if (held_nxt && s1_rep_r && (press_age >= {{(TW-MW){1'b0}}, repeat_delay_r})) begin
        event_nxt = bmcc_pkg::EV_CLICK;
      end

      click_age = s1_now_r - last_click_nxt;
      if (pending_nxt && !held_nxt && (click_age >= {{(TW-MW){1'b0}}, window_r})) begin
        case (click_count_nxt)
          2'd1:    event_nxt = bmcc_pkg::EV_CLICK;
          2'd2:    event_nxt = bmcc_pkg::EV_DOUBLE;
          default: event_nxt = bmcc_pkg::EV_TRIPLE;
        endcase
        click_count_nxt = '0;
        last_click_nxt  = '0;
        pending_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b0;
      held_r        <= 1'b0;
      press_time_r  <= '0;
      click_count_r <= '0;
      last_click_r  <= '0;
      pending_r     <= 1'b0;
    end else if (advance) begin
      prev_level_r  <= prev_level_nxt;
      held_r        <= held_nxt;
      press_time_r  <= press_time_nxt;
      click_count_r <= click_count_nxt;
      last_click_r  <= last_click_nxt;
      pending_r     <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r   <= event_nxt;
      out_pressed_r <= pressed_nxt;
    end
  end

  // a held press implies the stored level is pressed
  a_held_level: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> prev_level_r)
    else $error("held set while level released");

  // pending clicks always carry a non-zero count
  a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (click_count_r != 2'd0))
    else $error("click pending with zero count");

  // with nothing pending the count and time are cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> (click_count_r == 2'd0) && (last_click_r == '0))
    else $error("stale click state with nothing pending");

  // a long press is only reported on a pressed sample
  a_long_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r == bmcc_pkg::EV_LONG) |-> out_pressed_r)
    else $error("long press reported on a released sample");

  // an advancing beat always reaches the result register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("classified beat lost");

endmodule
